FILE: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue: request and result
// items, controller state, and controller to datapath command and status.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DATA_W = 8;
  localparam int PRIO_W = 8;
  localparam int OCC_W  = 5;
  localparam int STAT_W = 2;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_ENQUEUED    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DEQUEUED    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY       = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL_REFUSE = 2'd3;

  typedef struct packed {
    logic              operation;
    logic [DATA_W-1:0] item_data;
    logic [PRIO_W-1:0] item_priority;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] out_data;
    logic [PRIO_W-1:0] out_priority;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_REPLY
  } ctl_state_t;

  typedef struct packed {
    logic              insert;
    logic              remove;
    logic              respond;
    logic [STAT_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_status_t;

endpackage

FILE: sv/stable_priority_queue_top.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded priority queue, lowest priority value first, ties in arrival order.
// ----------------------------------------------------------------------------
// A request is taken on any clock edge with start high; busy never rises, so
// one request per cycle is sustained. Each request is finished in the cycle it
// is taken by a row of shift cells that compare the new priority in parallel,
// and its single result appears on out_item with out_valid high for exactly
// the next cycle. The receiver must take it then. Full enqueues and empty
// dequeues leave the queue unchanged and report their status. Cells hold no
// reset; only the entry count and the result strobe are cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  spq_pkg::in_item_t  in_item,
  output logic               out_valid,
  output spq_pkg::out_item_t out_item
);

  spq_pkg::dp_cmd_t    dp_cmd;
  spq_pkg::dp_status_t dp_status;
  logic                accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_item.operation),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd),
    .out_valid (out_valid)
  );

  spq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .dp_cmd    (dp_cmd),
    .in_item   (in_item),
    .dp_status (dp_status),
    .out_item  (out_item)
  );

endmodule

FILE: sv/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller: decodes an accepted request against the queue status into a
// datapath command and marks the cycle in which the result is shown.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                operation,
  input  spq_pkg::dp_status_t dp_status,
  output spq_pkg::dp_cmd_t    dp_cmd,
  output logic                out_valid
);

  spq_pkg::ctl_state_t state_r;
  spq_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = accept ? spq_pkg::ST_REPLY : spq_pkg::ST_IDLE;
  end

  always_comb begin
    out_valid      = (state_r == spq_pkg::ST_REPLY);
    dp_cmd.insert  = 1'b0;
    dp_cmd.remove  = 1'b0;
    dp_cmd.respond = accept;
    dp_cmd.status  = spq_pkg::STAT_ENQUEUED;
    if (operation == spq_pkg::OP_ENQUEUE) begin
      if (dp_status.full) begin
        dp_cmd.status = spq_pkg::STAT_FULL_REFUSE;
      end else begin
        dp_cmd.insert = accept;
        dp_cmd.status = spq_pkg::STAT_ENQUEUED;
      end
    end else begin
      if (dp_status.empty) begin
        dp_cmd.status = spq_pkg::STAT_EMPTY;
      end else begin
        dp_cmd.remove = accept;
        dp_cmd.status = spq_pkg::STAT_DEQUEUED;
      end
    end
  end

  a_reply_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("no result after accepted transfer");

  a_no_reply_unasked: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> !out_valid)
    else $error("result without accepted transfer");

endmodule

FILE: sv/spq_dp.sv
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: a row of sorted shift cells with an entry count. Every cell
// compares the new priority in parallel and inserts, shifts or holds; the
// result item is registered.
// ----------------------------------------------------------------------------
module spq_dp #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  spq_pkg::dp_cmd_t    dp_cmd,
  input  spq_pkg::in_item_t   in_item,
  output spq_pkg::dp_status_t dp_status,
  output spq_pkg::out_item_t  out_item
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int DATA_W = spq_pkg::DATA_W;
  localparam int PRIO_W = spq_pkg::PRIO_W;
  localparam int OCC_W  = spq_pkg::OCC_W;

  logic [PRIO_W-1:0] prio_r   [CAPACITY];
  logic [DATA_W-1:0] data_r   [CAPACITY];
  logic [PRIO_W-1:0] prio_nxt [CAPACITY];
  logic [DATA_W-1:0] data_nxt [CAPACITY];
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] at_end;
  logic [CAPACITY-1:0] prev_gt;
  logic [OCC_W+CNT_W-1:0] occ_wide;
  spq_pkg::out_item_t out_item_r;

  assign dp_status.full  = (count_r == CNT_W'(CAPACITY));
  assign dp_status.empty = (count_r == '0);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [PRIO_W-1:0] up_prio;
    logic [DATA_W-1:0] up_data;
    logic [PRIO_W-1:0] dn_prio;
    logic [DATA_W-1:0] dn_data;

    assign gt[i]     = (CNT_W'(i) < count_r) && (prio_r[i] > in_item.item_priority);
    assign at_end[i] = (CNT_W'(i) == count_r);

    if (i == 0) begin : g_first
      assign prev_gt[i] = 1'b0;
      assign up_prio    = prio_r[i];
      assign up_data    = data_r[i];
    end else begin : g_rest
      assign prev_gt[i] = gt[i-1];
      assign up_prio    = prio_r[i-1];
      assign up_data    = data_r[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign dn_prio = prio_r[i];
      assign dn_data = data_r[i];
    end else begin : g_inner
      assign dn_prio = prio_r[i+1];
      assign dn_data = data_r[i+1];
    end

    always_comb begin
      prio_nxt[i] = prio_r[i];
      data_nxt[i] = data_r[i];
      if (dp_cmd.insert) begin
        if (prev_gt[i]) begin
          prio_nxt[i] = up_prio;
          data_nxt[i] = up_data;
        end else if (gt[i] || at_end[i]) begin
          prio_nxt[i] = in_item.item_priority;
          data_nxt[i] = in_item.item_data;
        end
      end else if (dp_cmd.remove) begin
        prio_nxt[i] = dn_prio;
        data_nxt[i] = dn_data;
      end
    end

    always_ff @(posedge clk) begin
      prio_r[i] <= prio_nxt[i];
      data_r[i] <= data_nxt[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (dp_cmd.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (dp_cmd.remove) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // occupancy is the count after the step, masked to the field width
  assign occ_wide = {{OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (dp_cmd.respond) begin
      out_item_r.status       <= dp_cmd.status;
      out_item_r.out_data     <= dp_cmd.remove ? data_r[0] : '0;
      out_item_r.out_priority <= dp_cmd.remove ? prio_r[0] : '0;
      out_item_r.occupancy    <= occ_wide[OCC_W-1:0];
    end
  end

  assign out_item = out_item_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(dp_cmd.insert && dp_cmd.remove))
    else $error("insert and remove in one cycle");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.insert |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the queue");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(2) |-> prio_r[0] <= prio_r[1])
    else $error("head cells out of order");

endmodule

FILE: verif/tb_stable_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue_top
// Self-checking bench for the stable priority queue. Requests are queued by a
// directed list and by random fill, drain and mixed phases. A driver issues
// them in bursts with random gaps. A monitor keeps a sorted shadow queue and
// checks every result field.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue_top;

  localparam int CAPACITY     = 16;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 410;
  localparam int DATA_W       = spq_pkg::DATA_W;
  localparam int PRIO_W       = spq_pkg::PRIO_W;
  localparam int OCC_W        = spq_pkg::OCC_W;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  spq_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  spq_pkg::out_item_t out_item;

  spq_pkg::in_item_t  pending_reqs[$];
  spq_pkg::out_item_t expected_results[$];

  logic [DATA_W-1:0] shadow_data[CAPACITY];
  logic [PRIO_W-1:0] shadow_prio[CAPACITY];
  int                shadow_count = 0;

  logic took = 1'b0;
  int   burst_left = 1;
  int   gap_left = 0;
  int   error_count = 0;
  int   cycle_count = 0;
  int   n_enq = 0;
  int   n_full = 0;
  int   n_deq = 0;
  int   n_empty = 0;
  int   peak_occ = 0;

  stable_priority_queue_top #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow queue: sorted by priority, new entry after its ties
  function automatic spq_pkg::out_item_t queue_step(spq_pkg::in_item_t req);
    spq_pkg::out_item_t res;
    int pos;
    res = '0;
    if (req.operation == spq_pkg::OP_ENQUEUE) begin
      if (shadow_count >= CAPACITY) begin
        res.status = spq_pkg::STAT_FULL_REFUSE;
      end else begin
        pos = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_prio[i] > req.item_priority) pos = i;
        end
        for (int i = shadow_count; i > pos; i--) begin
          shadow_data[i] = shadow_data[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_data[pos] = req.item_data;
        shadow_prio[pos] = req.item_priority;
        shadow_count++;
        res.status = spq_pkg::STAT_ENQUEUED;
      end
    end else if (shadow_count == 0) begin
      res.status = spq_pkg::STAT_EMPTY;
    end else begin
      res.status       = spq_pkg::STAT_DEQUEUED;
      res.out_data     = shadow_data[0];
      res.out_priority = shadow_prio[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_data[i-1] = shadow_data[i];
        shadow_prio[i-1] = shadow_prio[i];
      end
      shadow_count--;
    end
    res.occupancy = OCC_W'(shadow_count);
    return res;
  endfunction

  task automatic add_enqueue(input logic [DATA_W-1:0] d, input logic [PRIO_W-1:0] p);
    spq_pkg::in_item_t req;
    req.operation     = spq_pkg::OP_ENQUEUE;
    req.item_data     = d;
    req.item_priority = p;
    pending_reqs.push_back(req);
  endtask

  task automatic add_dequeue(input logic [DATA_W-1:0] d, input logic [PRIO_W-1:0] p);
    spq_pkg::in_item_t req;
    req.operation     = spq_pkg::OP_DEQUEUE;
    req.item_data     = d;
    req.item_priority = p;
    pending_reqs.push_back(req);
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      error_count++;
    end
  endtask

  // driver: new request or idle at the falling edge
  always @(negedge clk) begin
    spq_pkg::in_item_t nxt;
    logic              nxt_start;
    if (rst_n && !(start && !took)) begin
      nxt_start = 1'b0;
      nxt = spq_pkg::in_item_t'($urandom);
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        nxt_start = 1'b1;
        nxt = pending_reqs.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      start   <= nxt_start;
      in_item <= nxt;
    end
  end

  // monitor: check the result of the previous transfer, then log this one
  always @(posedge clk) begin
    spq_pkg::out_item_t exp_r;
    cycle_count++;
    if (!rst_n) begin
      took = 1'b0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_item);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", exp_r.status, out_item.status);
          check_field("out_data", exp_r.out_data, out_item.out_data);
          check_field("out_priority", exp_r.out_priority, out_item.out_priority);
          check_field("occupancy", exp_r.occupancy, out_item.occupancy);
          case (exp_r.status)
            spq_pkg::STAT_ENQUEUED:    n_enq++;
            spq_pkg::STAT_DEQUEUED:    n_deq++;
            spq_pkg::STAT_EMPTY:       n_empty++;
            spq_pkg::STAT_FULL_REFUSE: n_full++;
            default: ;
          endcase
          if (exp_r.occupancy > peak_occ) peak_occ = exp_r.occupancy;
        end
      end
      took = start && !busy;
      if (took) expected_results.push_back(queue_step(in_item));
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: timeout, %0d results still outstanding", $time,
               expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int made;
    int kind;
    int span;
    int enq_pct;
    int prio_mode;
    int base;
    logic [PRIO_W-1:0] p;

    // directed: empty dequeue, extremes, ties, fill to full, refusal, partial drain
    add_dequeue(8'hFF, 8'hFF);
    add_enqueue(8'hFF, 8'hFF);
    add_enqueue(8'h00, 8'h00);
    add_enqueue(8'h55, 8'h80);
    add_enqueue(8'hAA, 8'h80);
    add_enqueue(8'h11, 8'h00);
    add_enqueue(8'h22, 8'hFF);
    add_enqueue(8'h33, 8'h80);
    add_enqueue(8'h44, 8'h7F);
    add_enqueue(8'h66, 8'h81);
    add_enqueue(8'h77, 8'h01);
    add_enqueue(8'h88, 8'hFE);
    add_enqueue(8'h99, 8'h80);
    add_enqueue(8'hBB, 8'h00);
    add_enqueue(8'hCC, 8'hFF);
    add_enqueue(8'hDD, 8'h40);
    add_enqueue(8'hEE, 8'h80);
    add_enqueue(8'h5A, 8'h00);
    add_dequeue(8'h00, 8'h00);
    add_enqueue(8'hA5, 8'h00);
    add_enqueue(8'h3C, 8'h10);
    for (int i = 0; i < 4; i++) add_dequeue(8'h00, 8'h00);

    // random phases: fill, drain and mixed, with varied priority spreads
    made = 0;
    while (made < RANDOM_ITEMS) begin
      kind      = $urandom_range(0, 2);
      span      = $urandom_range(10, 40);
      enq_pct   = (kind == 0) ? 85 : (kind == 1) ? 15 : 50;
      prio_mode = $urandom_range(0, 3);
      base      = $urandom_range(0, 252);
      for (int i = 0; i < span; i++) begin
        case (prio_mode)
          0:       p = PRIO_W'($urandom_range(0, 3));
          1:       p = PRIO_W'($urandom);
          2:       p = ($urandom_range(0, 1) == 0) ? PRIO_W'($urandom_range(0, 1))
                                                   : PRIO_W'($urandom_range(254, 255));
          default: p = PRIO_W'(base + $urandom_range(0, 3));
        endcase
        if ($urandom_range(1, 100) <= enq_pct) add_enqueue(DATA_W'($urandom), p);
        else add_dequeue(DATA_W'($urandom), PRIO_W'($urandom));
      end
      made += span;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d enqueues, %0d full refusals, %0d dequeues, %0d empty dequeues",
             n_enq, n_full, n_deq, n_empty);
    $display("peak occupancy %0d of %0d, %0d field mismatches", peak_occ, CAPACITY,
             error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
